// ----- hw/rtl/nmeaps_pkg.sv -----
// ---------------------------------------------------------------------------
// NMEA position and speed extractor: shared definitions
// Character codes, sentence kinds, header match states, numeric limits and
// the result word that travels from the parser to the output buffer.
// ---------------------------------------------------------------------------
`default_nettype none

package nmeaps_pkg;

   localparam int DEF_MAX_DIGITS      = 12;
   localparam int DEF_MAX_FIELD_CHARS = 16;

   localparam int MANT_W  = 40;
   localparam int FRAC_W  = 4;
   localparam int SPEED_W = 16;
   localparam int FIELD_W = 4;

   localparam logic [MANT_W-1:0]  MANT_MASK = {MANT_W{1'b1}};
   localparam logic [MANT_W-1:0]  ACC_LIMIT = (MANT_MASK - 40'd9) / 40'd10;
   localparam logic [FRAC_W-1:0]  FRAC_MAX  = 4'd15;
   localparam logic [SPEED_W-1:0] SPEED_MAX = 16'hFFFF;
   localparam logic [FIELD_W-1:0] FIELD_MAX = 4'd15;

   localparam logic [FIELD_W-1:0] FIELD_LAT   = 4'd1;
   localparam logic [FIELD_W-1:0] FIELD_LON   = 4'd3;
   localparam logic [FIELD_W-1:0] FIELD_SPEED = 4'd7;

   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_CR     = 8'h0D;
   localparam logic [7:0] CHAR_LF     = 8'h0A;
   localparam logic [7:0] CHAR_COMMA  = 8'h2C;
   localparam logic [7:0] CHAR_POINT  = 8'h2E;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;
   localparam logic [7:0] CHAR_G      = 8'h47;
   localparam logic [7:0] CHAR_N      = 8'h4E;
   localparam logic [7:0] CHAR_R      = 8'h52;
   localparam logic [7:0] CHAR_M      = 8'h4D;
   localparam logic [7:0] CHAR_C      = 8'h43;
   localparam logic [7:0] CHAR_L      = 8'h4C;

   localparam logic RESULT_GLL = 1'b0;
   localparam logic RESULT_RMC = 1'b1;

   typedef enum logic [1:0] {
      KIND_NONE = 2'd0,
      KIND_GLL  = 2'd1,
      KIND_RMC  = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      HDR_IDLE   = 3'd0,
      HDR_DOLLAR = 3'd1,
      HDR_G      = 3'd2,
      HDR_GN     = 3'd3,
      HDR_GNR    = 3'd4,
      HDR_GNRM   = 3'd5,
      HDR_GNG    = 3'd6,
      HDR_GNGL   = 3'd7
   } hdr_state_type;

   typedef struct packed {
      logic                sentence_kind;
      logic [MANT_W-1:0]   lat_mantissa;
      logic [FRAC_W-1:0]   lat_frac_digits;
      logic [MANT_W-1:0]   lon_mantissa;
      logic [FRAC_W-1:0]   lon_frac_digits;
      logic [SPEED_W-1:0]  speed_knots;
      logic                digit_overflow;
   } result_type;

endpackage

`default_nettype wire

// ----- hw/rtl/nmeaps_parser.sv -----
// ---------------------------------------------------------------------------
// NMEA sentence parser
// Matches the GNGLL and GNRMC headers, counts fields, accumulates the
// position and speed numbers and forms a result word when CR LF arrives.
// ---------------------------------------------------------------------------
`default_nettype none

module nmeaps_parser #(
   parameter int MAX_DIGITS      = nmeaps_pkg::DEF_MAX_DIGITS,
   parameter int MAX_FIELD_CHARS = nmeaps_pkg::DEF_MAX_FIELD_CHARS
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   accept,
   input  wire logic [7:0]             rx_byte,
   output logic                        res_valid,
   output nmeaps_pkg::result_type      res
);

   localparam int DW = $clog2(MAX_DIGITS + 1);
   localparam int CW = $clog2(MAX_FIELD_CHARS + 1);

   nmeaps_pkg::hdr_state_type hdr_ff, hdr_in;
   nmeaps_pkg::kind_type      kind_ff, kind_in;
   logic [nmeaps_pkg::FIELD_W-1:0] field_idx_ff, field_idx_in;
   logic [CW-1:0]                  char_cnt_ff, char_cnt_in;
   logic                           cr_seen_ff, cr_seen_in;
   logic                           point_seen_ff, point_seen_in;
   logic [nmeaps_pkg::MANT_W-1:0]  accum_ff, accum_in;
   logic [nmeaps_pkg::FRAC_W-1:0]  frac_cnt_ff, frac_cnt_in;
   logic [DW-1:0]                  digit_cnt_ff, digit_cnt_in;
   logic [nmeaps_pkg::MANT_W-1:0]  lat_ff, lat_in;
   logic [nmeaps_pkg::FRAC_W-1:0]  lat_frac_ff, lat_frac_in;
   logic [nmeaps_pkg::MANT_W-1:0]  lon_ff, lon_in;
   logic [nmeaps_pkg::FRAC_W-1:0]  lon_frac_ff, lon_frac_in;
   logic [nmeaps_pkg::SPEED_W-1:0] speed_ff, speed_in;
   logic                           ovf_ff, ovf_in;

   logic                           is_digit;
   logic [nmeaps_pkg::MANT_W-1:0]  accum_x10;
   logic                           in_pos_field;
   logic                           in_speed_field;
   logic [nmeaps_pkg::MANT_W-1:0]  lat_cl, lon_cl;
   logic [nmeaps_pkg::FRAC_W-1:0]  lat_frac_cl, lon_frac_cl;
   logic [nmeaps_pkg::SPEED_W-1:0] speed_cl;
   logic                           line_end;

   assign is_digit  = (rx_byte >= nmeaps_pkg::CHAR_ZERO) && (rx_byte <= nmeaps_pkg::CHAR_NINE);
   // Times ten as two shifts and an add; the digit value is the low nibble.
   assign accum_x10 = (accum_ff << 3) + (accum_ff << 1)
                    + {{(nmeaps_pkg::MANT_W-4){1'b0}}, (is_digit ? rx_byte[3:0] : 4'd0)};

   assign in_pos_field   = (kind_ff == nmeaps_pkg::KIND_GLL) &&
                           ((field_idx_ff == nmeaps_pkg::FIELD_LAT) ||
                            (field_idx_ff == nmeaps_pkg::FIELD_LON));
   assign in_speed_field = (kind_ff == nmeaps_pkg::KIND_RMC) &&
                           (field_idx_ff == nmeaps_pkg::FIELD_SPEED);

   // Store contents as they stand once the current field is closed.
   always_comb begin
      lat_cl      = lat_ff;
      lat_frac_cl = lat_frac_ff;
      lon_cl      = lon_ff;
      lon_frac_cl = lon_frac_ff;
      speed_cl    = speed_ff;
      if (kind_ff == nmeaps_pkg::KIND_GLL && field_idx_ff == nmeaps_pkg::FIELD_LAT) begin
         lat_cl      = accum_ff;
         lat_frac_cl = frac_cnt_ff;
      end
      if (kind_ff == nmeaps_pkg::KIND_GLL && field_idx_ff == nmeaps_pkg::FIELD_LON) begin
         lon_cl      = accum_ff;
         lon_frac_cl = frac_cnt_ff;
      end
      if (in_speed_field) begin
         if (accum_ff > {{(nmeaps_pkg::MANT_W-nmeaps_pkg::SPEED_W){1'b0}},
                         nmeaps_pkg::SPEED_MAX}) begin
            speed_cl = nmeaps_pkg::SPEED_MAX;
         end else begin
            speed_cl = accum_ff[nmeaps_pkg::SPEED_W-1:0];
         end
      end
   end

   assign line_end = (rx_byte != nmeaps_pkg::CHAR_DOLLAR) &&
                     (kind_ff != nmeaps_pkg::KIND_NONE) &&
                     (rx_byte == nmeaps_pkg::CHAR_LF) && cr_seen_ff;

   // Next state.
   always_comb begin
      logic                 do_start;
      nmeaps_pkg::kind_type start_kind;
      logic                 do_clear_field;

      do_start       = 1'b0;
      start_kind     = nmeaps_pkg::KIND_NONE;
      do_clear_field = 1'b0;

      hdr_in        = hdr_ff;
      kind_in       = kind_ff;
      field_idx_in  = field_idx_ff;
      char_cnt_in   = char_cnt_ff;
      cr_seen_in    = cr_seen_ff;
      point_seen_in = point_seen_ff;
      accum_in      = accum_ff;
      frac_cnt_in   = frac_cnt_ff;
      digit_cnt_in  = digit_cnt_ff;
      lat_in        = lat_ff;
      lat_frac_in   = lat_frac_ff;
      lon_in        = lon_ff;
      lon_frac_in   = lon_frac_ff;
      speed_in      = speed_ff;
      ovf_in        = ovf_ff;

      if (accept) begin
         if (rx_byte == nmeaps_pkg::CHAR_DOLLAR) begin
            do_start   = 1'b1;
            start_kind = nmeaps_pkg::KIND_NONE;
         end else if (kind_ff == nmeaps_pkg::KIND_NONE) begin
            hdr_in = nmeaps_pkg::HDR_IDLE;
            case (hdr_ff)
               nmeaps_pkg::HDR_DOLLAR: begin
                  if (rx_byte == nmeaps_pkg::CHAR_G) hdr_in = nmeaps_pkg::HDR_G;
               end
               nmeaps_pkg::HDR_G: begin
                  if (rx_byte == nmeaps_pkg::CHAR_N) hdr_in = nmeaps_pkg::HDR_GN;
               end
               nmeaps_pkg::HDR_GN: begin
                  if (rx_byte == nmeaps_pkg::CHAR_R) hdr_in = nmeaps_pkg::HDR_GNR;
                  else if (rx_byte == nmeaps_pkg::CHAR_G) hdr_in = nmeaps_pkg::HDR_GNG;
               end
               nmeaps_pkg::HDR_GNR: begin
                  if (rx_byte == nmeaps_pkg::CHAR_M) hdr_in = nmeaps_pkg::HDR_GNRM;
               end
               nmeaps_pkg::HDR_GNRM: begin
                  if (rx_byte == nmeaps_pkg::CHAR_C) begin
                     do_start   = 1'b1;
                     start_kind = nmeaps_pkg::KIND_RMC;
                  end
               end
               nmeaps_pkg::HDR_GNG: begin
                  if (rx_byte == nmeaps_pkg::CHAR_L) hdr_in = nmeaps_pkg::HDR_GNGL;
               end
               nmeaps_pkg::HDR_GNGL: begin
                  if (rx_byte == nmeaps_pkg::CHAR_L) begin
                     do_start   = 1'b1;
                     start_kind = nmeaps_pkg::KIND_GLL;
                  end
               end
               default: begin
                  hdr_in = nmeaps_pkg::HDR_IDLE;
               end
            endcase
         end else if (line_end) begin
            do_start   = 1'b1;
            start_kind = nmeaps_pkg::KIND_NONE;
         end else if (rx_byte == nmeaps_pkg::CHAR_CR) begin
            cr_seen_in = 1'b1;
         end else begin
            cr_seen_in = 1'b0;
            if (rx_byte == nmeaps_pkg::CHAR_COMMA) begin
               lat_in         = lat_cl;
               lat_frac_in    = lat_frac_cl;
               lon_in         = lon_cl;
               lon_frac_in    = lon_frac_cl;
               speed_in       = speed_cl;
               do_clear_field = 1'b1;
               if (field_idx_ff < nmeaps_pkg::FIELD_MAX) begin
                  field_idx_in = field_idx_ff + 4'd1;
               end
            end else if (char_cnt_ff < CW'(MAX_FIELD_CHARS)) begin
               char_cnt_in = char_cnt_ff + CW'(1);
               if (in_pos_field) begin
                  if (rx_byte == nmeaps_pkg::CHAR_POINT) begin
                     point_seen_in = 1'b1;
                  end else if (is_digit) begin
                     if (digit_cnt_ff >= DW'(MAX_DIGITS) ||
                         accum_ff > nmeaps_pkg::ACC_LIMIT ||
                         (point_seen_ff && frac_cnt_ff >= nmeaps_pkg::FRAC_MAX)) begin
                        ovf_in = 1'b1;
                     end else begin
                        accum_in     = accum_x10;
                        digit_cnt_in = digit_cnt_ff + DW'(1);
                        if (point_seen_ff) frac_cnt_in = frac_cnt_ff + 4'd1;
                     end
                  end
               end else if (in_speed_field && !point_seen_ff) begin
                  // The first non-digit ends the integer part of the speed.
                  if (is_digit) begin
                     if (accum_x10 > {{(nmeaps_pkg::MANT_W-nmeaps_pkg::SPEED_W){1'b0}},
                                      nmeaps_pkg::SPEED_MAX}) begin
                        accum_in = {{(nmeaps_pkg::MANT_W-nmeaps_pkg::SPEED_W){1'b0}},
                                    nmeaps_pkg::SPEED_MAX};
                     end else begin
                        accum_in = accum_x10;
                     end
                  end else begin
                     point_seen_in = 1'b1;
                  end
               end
            end
         end
      end

      if (do_clear_field) begin
         char_cnt_in   = '0;
         point_seen_in = 1'b0;
         accum_in      = '0;
         frac_cnt_in   = '0;
         digit_cnt_in  = '0;
      end

      if (do_start) begin
         kind_in       = start_kind;
         hdr_in        = (rx_byte == nmeaps_pkg::CHAR_DOLLAR) ? nmeaps_pkg::HDR_DOLLAR
                                                             : nmeaps_pkg::HDR_IDLE;
         field_idx_in  = '0;
         cr_seen_in    = 1'b0;
         lat_in        = '0;
         lat_frac_in   = '0;
         lon_in        = '0;
         lon_frac_in   = '0;
         speed_in      = '0;
         ovf_in        = 1'b0;
         char_cnt_in   = '0;
         point_seen_in = 1'b0;
         accum_in      = '0;
         frac_cnt_in   = '0;
         digit_cnt_in  = '0;
      end
   end

   // Result word.
   always_comb begin
      logic gll;
      gll       = (kind_ff == nmeaps_pkg::KIND_GLL);
      res_valid = accept && line_end;
      res.sentence_kind   = gll ? nmeaps_pkg::RESULT_GLL : nmeaps_pkg::RESULT_RMC;
      res.lat_mantissa    = gll ? lat_cl : '0;
      res.lat_frac_digits = gll ? lat_frac_cl : '0;
      res.lon_mantissa    = gll ? lon_cl : '0;
      res.lon_frac_digits = gll ? lon_frac_cl : '0;
      res.speed_knots     = gll ? '0 : speed_cl;
      res.digit_overflow  = ovf_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_ff        <= nmeaps_pkg::HDR_IDLE;
         kind_ff       <= nmeaps_pkg::KIND_NONE;
         field_idx_ff  <= '0;
         char_cnt_ff   <= '0;
         cr_seen_ff    <= 1'b0;
         point_seen_ff <= 1'b0;
         accum_ff      <= '0;
         frac_cnt_ff   <= '0;
         digit_cnt_ff  <= '0;
         lat_ff        <= '0;
         lat_frac_ff   <= '0;
         lon_ff        <= '0;
         lon_frac_ff   <= '0;
         speed_ff      <= '0;
         ovf_ff        <= 1'b0;
      end else begin
         hdr_ff        <= hdr_in;
         kind_ff       <= kind_in;
         field_idx_ff  <= field_idx_in;
         char_cnt_ff   <= char_cnt_in;
         cr_seen_ff    <= cr_seen_in;
         point_seen_ff <= point_seen_in;
         accum_ff      <= accum_in;
         frac_cnt_ff   <= frac_cnt_in;
         digit_cnt_ff  <= digit_cnt_in;
         lat_ff        <= lat_in;
         lat_frac_ff   <= lat_frac_in;
         lon_ff        <= lon_in;
         lon_frac_ff   <= lon_frac_in;
         speed_ff      <= speed_in;
         ovf_ff        <= ovf_in;
      end
   end

`ifndef SYNTHESIS
   a_char_bound: assert property (@(posedge clock) disable iff (reset)
      char_cnt_ff <= CW'(MAX_FIELD_CHARS))
      else $error("field character count beyond limit");

   a_frac_within_digits: assert property (@(posedge clock) disable iff (reset)
      (kind_ff == nmeaps_pkg::KIND_GLL) |->
         (int'(frac_cnt_ff) <= int'(digit_cnt_ff)))
      else $error("more fraction digits than kept digits");

   a_result_ends_sentence: assert property (@(posedge clock) disable iff (reset)
      res_valid |=> (kind_ff == nmeaps_pkg::KIND_NONE && hdr_ff == nmeaps_pkg::HDR_IDLE))
      else $error("sentence still open after its result");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/nmeaps_out_buf.sv -----
// ---------------------------------------------------------------------------
// Result output buffer
// An output register backed by one skid entry, so the input side keeps
// taking bytes while a result waits to be taken.
// ---------------------------------------------------------------------------
`default_nettype none

module nmeaps_out_buf (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    push,
   input  wire nmeaps_pkg::result_type  push_data,
   output logic                         can_push,
   output logic                         out_valid,
   input  wire logic                    out_ready,
   output nmeaps_pkg::result_type       out_data
);

   logic                   main_valid_ff, main_valid_in;
   logic                   skid_valid_ff, skid_valid_in;
   nmeaps_pkg::result_type main_ff, main_in;
   nmeaps_pkg::result_type skid_ff, skid_in;
   logic                   pop;

   assign pop       = main_valid_ff && out_ready;
   assign can_push  = !skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end else if (push) begin
            main_in = push_data;
         end else begin
            main_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!main_valid_ff) begin
            main_in       = push_data;
            main_valid_in = 1'b1;
         end else begin
            skid_in       = push_data;
            skid_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

`ifndef SYNTHESIS
   a_skid_behind_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid entry held with the output register empty");

   a_push_lands: assert property (@(posedge clock) disable iff (reset)
      (push && can_push) |=> main_valid_ff)
      else $error("pushed result not visible at the output");

   a_drain_empties: assert property (@(posedge clock) disable iff (reset)
      (pop && !skid_valid_ff && !push) |=> !main_valid_ff)
      else $error("output stays valid after its last result was taken");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/nmea_position_speed_extractor.sv -----
// Results enter the output register (or its skid entry if full) when their LF byte is taken.
// Throughput: one byte per cycle while req_ready is high; header matching, field counting
// and the times-ten accumulate all finish in the cycle the byte is taken.
// req_ready falls only while two results wait in the output register and its skid entry.
// Reset (synchronous, active high) clears the parser state, all stores and both
// output entries; no sentence is open after reset.
// ---------------------------------------------------------------------------
// NMEA position and speed extractor
// Parses GNGLL and GNRMC sentences from a byte stream and returns latitude,
// longitude or integer ground speed for each complete sentence.
// ---------------------------------------------------------------------------
`default_nettype none

module nmea_position_speed_extractor #(
   parameter int MAX_DIGITS      = nmeaps_pkg::DEF_MAX_DIGITS,
   parameter int MAX_FIELD_CHARS = nmeaps_pkg::DEF_MAX_FIELD_CHARS
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [7:0]                          req_rx_byte,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic                                     rsp_sentence_kind,
   output logic [nmeaps_pkg::MANT_W-1:0]            rsp_lat_mantissa,
   output logic [nmeaps_pkg::FRAC_W-1:0]            rsp_lat_frac_digits,
   output logic [nmeaps_pkg::MANT_W-1:0]            rsp_lon_mantissa,
   output logic [nmeaps_pkg::FRAC_W-1:0]            rsp_lon_frac_digits,
   output logic [nmeaps_pkg::SPEED_W-1:0]           rsp_speed_knots,
   output logic                                     rsp_digit_overflow
);

   logic                   accept;
   logic                   res_valid;
   nmeaps_pkg::result_type res;
   nmeaps_pkg::result_type out_data;

   assign accept = req_valid && req_ready;

   nmeaps_parser #(
      .MAX_DIGITS      (MAX_DIGITS),
      .MAX_FIELD_CHARS (MAX_FIELD_CHARS)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .rx_byte   (req_rx_byte),
      .res_valid (res_valid),
      .res       (res)
   );

   nmeaps_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data (res),
      .can_push  (req_ready),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (out_data)
   );

   assign rsp_sentence_kind   = out_data.sentence_kind;
   assign rsp_lat_mantissa    = out_data.lat_mantissa;
   assign rsp_lat_frac_digits = out_data.lat_frac_digits;
   assign rsp_lon_mantissa    = out_data.lon_mantissa;
   assign rsp_lon_frac_digits = out_data.lon_frac_digits;
   assign rsp_speed_knots     = out_data.speed_knots;
   assign rsp_digit_overflow  = out_data.digit_overflow;

endmodule

`default_nettype wire
